@@ src/alrs_pkg.sv @@
// Package for the append-only log scanner: slot geometry, record constants,
// the result type and the byte-wide reflected CRC-32 step.
// Used by the channel interfaces and by append_log_latest_record_scan.
package alrs_pkg;

    // Page and record geometry.
    localparam int SLOT_BYTES    = 272;
    localparam int SLOT_COUNT    = 7;
    localparam int PAYLOAD_BYTES = 252;
    localparam int PAYLOAD_START = 16;
    localparam int COMMIT_AT     = PAYLOAD_START + PAYLOAD_BYTES;

    localparam int OFF_W  = $clog2(SLOT_BYTES);
    localparam int SLOT_W = $clog2(SLOT_COUNT + 1);

    // Record constants.
    localparam logic [31:0] LOG_MAGIC   = 32'h5650_4B54;
    localparam logic [31:0] LOG_COMMIT  = 32'h5449_4D43;
    localparam logic [15:0] LOG_VERSION = 16'd8;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;

    typedef logic [OFF_W-1:0]  offset_t;
    typedef logic [SLOT_W-1:0] slot_t;

    // One verdict as it leaves the block.
    typedef struct packed {
        logic [2:0]  slot_number;
        logic        slot_erased;
        logic        slot_valid;
        logic [31:0] slot_sequence;
        logic        latest_found;
        logic [2:0]  latest_slot;
        logic [31:0] latest_sequence;
        logic [2:0]  next_free_slot;
        logic        scan_finished;
    } result_t;

    // Reflected CRC-32 over one byte, eight shift steps unrolled.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'h0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Slot index narrowed or widened to the three-bit result fields.
    function automatic logic [2:0] slot3(input logic [31:0] s);
        return s[2:0];
    endfunction

endpackage

@@ src/alrs_if.sv @@
// Channel interfaces of the log scanner: the page byte stream and the verdicts.
// Depends on alrs_pkg for the verdict type.
interface alrs_page_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       page_start;

    modport source (output valid, byte_value, page_start, input ready);
    modport sink   (input valid, byte_value, page_start, output ready);
endinterface

interface alrs_verdict_if;
    logic              valid;
    logic              ready;
    alrs_pkg::result_t payload;

    modport source (output valid, payload, input ready);
    modport sink   (input valid, payload, output ready);
endinterface

@@ src/append_log_latest_record_scan.sv @@
// A verdict is in the output register in the cycle after the byte that ends a slot
// (the last slot byte, or the eighth byte of an erased slot) is transferred.
// Throughput: one byte per cycle while no verdict waits; the CRC step and field capture finish in that cycle.
// A verdict that waits while the receiver stalls holds off further bytes until it is taken.
// Reset (rst_n low, asynchronous) arms a scan at slot 0, offset 0 and clears the latest record.
module append_log_latest_record_scan (
    input logic           clk,
    input logic           rst_n,
    alrs_page_if.sink     page,
    alrs_verdict_if.source verdict
);
    import alrs_pkg::*;

    // Scan state.
    offset_t     off_reg, off_next;
    slot_t       slot_reg, slot_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] magic_reg, magic_next;
    logic [15:0] version_reg, version_next;
    logic [15:0] size_reg, size_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] hcrc_reg, hcrc_next;
    logic [31:0] commit_reg, commit_next;
    logic        ones_reg, ones_next;
    logic        best_present_reg, best_present_next;
    slot_t       best_slot_reg, best_slot_next;
    logic [31:0] best_seq_reg, best_seq_next;
    logic        scan_over_reg, scan_over_next;

    // Output register.
    logic        res_valid_reg, res_valid_next;
    result_t     res_reg, res_next;

    logic        accept, process, result_load;
    logic        restart, first_byte, erased_hit, last_byte, rec_valid, finished, better;
    offset_t     eff_off;
    slot_t       eff_slot;
    logic        eff_scan_over, eff_best_present;
    slot_t       eff_best_slot;
    logic [31:0] eff_best_seq;
    logic [31:0] off32, commit_idx;
    logic [7:0]  b;

    assign page.ready    = !res_valid_reg || verdict.ready;
    assign accept        = page.valid && page.ready;
    assign verdict.valid = res_valid_reg;
    assign verdict.payload = res_reg;

    // Byte decode, record assembly, CRC update and slot verdict.
    always_comb
    begin
        b       = page.byte_value;
        restart = page.page_start;

        eff_off          = restart ? '0 : off_reg;
        eff_slot         = restart ? '0 : slot_reg;
        eff_scan_over    = restart ? 1'b0 : scan_over_reg;
        eff_best_present = restart ? 1'b0 : best_present_reg;
        eff_best_slot    = restart ? '0 : best_slot_reg;
        eff_best_seq     = restart ? '0 : best_seq_reg;

        off32      = 32'(eff_off);
        commit_idx = off32 - 32'(COMMIT_AT);
        first_byte = (eff_off == '0);

        // A new slot starts from cleared fields and a fresh CRC.
        magic_next   = first_byte ? '0 : magic_reg;
        version_next = first_byte ? '0 : version_reg;
        size_next    = first_byte ? '0 : size_reg;
        seq_next     = first_byte ? '0 : seq_reg;
        hcrc_next    = first_byte ? '0 : hcrc_reg;
        commit_next  = first_byte ? '0 : commit_reg;
        crc_next     = first_byte ? CRC_INIT : crc_reg;
        ones_next    = first_byte ? 1'b1 : ones_reg;

        if (off32 < 32'd8 && b != 8'hFF)
        begin
            ones_next = 1'b0;
        end

        // Little-endian byte lanes of the header and trailer.
        if (off32 < 32'd4)
        begin
            magic_next[{off32[1:0], 3'b000} +: 8] = b;
        end
        else if (off32 < 32'd6)
        begin
            version_next[{off32[0], 3'b000} +: 8] = b;
        end
        else if (off32 < 32'd8)
        begin
            size_next[{off32[0], 3'b000} +: 8] = b;
        end
        else if (off32 < 32'd12)
        begin
            seq_next[{off32[1:0], 3'b000} +: 8] = b;
        end
        else if (off32 < 32'd16)
        begin
            hcrc_next[{off32[1:0], 3'b000} +: 8] = b;
        end
        else if (off32 >= 32'(COMMIT_AT) && off32 < 32'(COMMIT_AT + 4))
        begin
            commit_next[{commit_idx[1:0], 3'b000} +: 8] = b;
        end

        // CRC covers version, size, sequence and payload.
        if ((off32 >= 32'd4 && off32 < 32'd12) ||
            (off32 >= 32'(PAYLOAD_START) && off32 < 32'(COMMIT_AT)))
        begin
            crc_next = crc32_byte(crc_next, b);
        end

        erased_hit = (off32 == 32'd7) && ones_next;
        last_byte  = (off32 + 32'd1 >= 32'(SLOT_BYTES));
        rec_valid  = (magic_next == LOG_MAGIC) && (version_next == LOG_VERSION)
                  && (size_next == 16'(PAYLOAD_BYTES)) && (commit_next == LOG_COMMIT)
                  && (hcrc_next == ~crc_next);
        finished   = (32'(eff_slot) + 32'd1 >= 32'(SLOT_COUNT));
        better     = rec_valid && (!eff_best_present || seq_next >= eff_best_seq);

        process = accept && !eff_scan_over;

        off_next          = off_reg;
        slot_next         = slot_reg;
        best_present_next = best_present_reg;
        best_slot_next    = best_slot_reg;
        best_seq_next     = best_seq_reg;
        scan_over_next    = scan_over_reg;
        result_load       = 1'b0;
        res_next          = res_reg;

        if (process)
        begin
            slot_next         = eff_slot;
            best_present_next = eff_best_present;
            best_slot_next    = eff_best_slot;
            best_seq_next     = eff_best_seq;
            scan_over_next    = 1'b0;
            if (erased_hit)
            begin
                // Erased slot: report it as the first free slot and stop.
                off_next                 = eff_off;
                scan_over_next           = 1'b1;
                result_load              = 1'b1;
                res_next.slot_number     = slot3(32'(eff_slot));
                res_next.slot_erased     = 1'b1;
                res_next.slot_valid      = 1'b0;
                res_next.slot_sequence   = '0;
                res_next.latest_found    = eff_best_present;
                res_next.latest_slot     = slot3(32'(eff_best_slot));
                res_next.latest_sequence = eff_best_seq;
                res_next.next_free_slot  = slot3(32'(eff_slot));
                res_next.scan_finished   = 1'b1;
            end
            else if (last_byte)
            begin
                // Slot complete: judge it and fold it into the latest record.
                if (better)
                begin
                    best_present_next = 1'b1;
                    best_slot_next    = eff_slot;
                    best_seq_next     = seq_next;
                end
                off_next                 = '0;
                slot_next                = eff_slot + slot_t'(1);
                scan_over_next           = finished;
                result_load              = 1'b1;
                res_next.slot_number     = slot3(32'(eff_slot));
                res_next.slot_erased     = 1'b0;
                res_next.slot_valid      = rec_valid;
                res_next.slot_sequence   = seq_next;
                res_next.latest_found    = best_present_next;
                res_next.latest_slot     = slot3(32'(best_slot_next));
                res_next.latest_sequence = best_seq_next;
                res_next.next_free_slot  = slot3(32'(eff_slot) + 32'd1);
                res_next.scan_finished   = finished;
            end
            else
            begin
                off_next = eff_off + offset_t'(1);
            end
        end

        res_valid_next = result_load || (res_valid_reg && !verdict.ready);
    end

    // Control state, reset to an armed scan.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg          <= '0;
            slot_reg         <= '0;
            ones_reg         <= 1'b1;
            best_present_reg <= 1'b0;
            best_slot_reg    <= '0;
            best_seq_reg     <= '0;
            scan_over_reg    <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            off_reg          <= off_next;
            slot_reg         <= slot_next;
            best_present_reg <= best_present_next;
            best_slot_reg    <= best_slot_next;
            best_seq_reg     <= best_seq_next;
            scan_over_reg    <= scan_over_next;
            res_valid_reg    <= res_valid_next;
            if (process)
            begin
                ones_reg <= ones_next;
            end
        end
    end

    // Record fields and the result payload, taken only when a byte is worked on.
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            crc_reg     <= crc_next;
            magic_reg   <= magic_next;
            version_reg <= version_next;
            size_reg    <= size_next;
            seq_reg     <= seq_next;
            hcrc_reg    <= hcrc_next;
            commit_reg  <= commit_next;
        end
        if (result_load)
        begin
            res_reg <= res_next;
        end
    end

    // An erased slot is never also a valid record.
    a_erased_not_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_reg.slot_erased && res_reg.slot_valid))
        else $error("verdict both erased and valid");

    // An erased slot ends the scan and is itself the first free slot.
    a_erased_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.slot_erased) |->
            (res_reg.scan_finished && res_reg.next_free_slot == res_reg.slot_number
             && res_reg.slot_sequence == 32'd0))
        else $error("erased verdict fields inconsistent");

    // Bytes after the end of a scan produce no verdict.
    a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && scan_over_reg && !page.page_start) |-> !result_load)
        else $error("verdict after end of scan");

    // The slot offset stays within the slot.
    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(off_reg) < 32'(SLOT_BYTES))
        else $error("slot offset out of range");

    // Without a valid record the latest-record fields read as zero.
    a_latest_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.latest_found) |->
            (res_reg.latest_slot == 3'd0 && res_reg.latest_sequence == 32'd0))
        else $error("latest record reported without a valid record");

    // A new verdict never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !verdict.ready) |-> !result_load)
        else $error("waiting verdict overwritten");

endmodule

@@ dv/alrs_scan_checker.sv @@
// Scoreboard for append_log_latest_record_scan: predicts each slot verdict from the byte
// transfers on the page channel and compares it with the verdict channel.
// Depends on alrs_pkg and on the channel interfaces in alrs_if.sv.
module alrs_scan_checker
    import alrs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    alrs_page_if    page,
    alrs_verdict_if verdict,
    output int      mismatch_total,
    output int      verdicts_owed
);

    // Predicted scan state, one copy of everything the block keeps.
    offset_t     rec_pos;
    slot_t       slot_idx;
    logic [31:0] crc_acc;
    logic [31:0] rec_magic;
    logic [15:0] rec_version;
    logic [15:0] rec_size;
    logic [31:0] rec_seq;
    logic [31:0] rec_crc;
    logic [31:0] rec_commit;
    logic        hdr_all_ones;
    logic        have_best;
    slot_t       best_idx;
    logic [31:0] best_seq;
    logic        scan_done;

    // Verdicts predicted but not yet seen, oldest first.
    result_t     verdicts_due[$];
    int          verdicts_seen;

    // Reflected CRC-32 update over one byte.
    function automatic logic [31:0] crc_shift8(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'h0, b};
        repeat (8)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
        end
        return c;
    endfunction

    // Forget the record being assembled.
    function automatic void clear_record();
        rec_pos      = '0;
        crc_acc      = CRC_INIT;
        rec_magic    = '0;
        rec_version  = '0;
        rec_size     = '0;
        rec_seq      = '0;
        rec_crc      = '0;
        rec_commit   = '0;
        hdr_all_ones = 1'b1;
    endfunction

    // Arm a new scan at slot 0 with no latest record.
    function automatic void restart_page();
        clear_record();
        slot_idx  = '0;
        have_best = 1'b0;
        best_idx  = '0;
        best_seq  = '0;
        scan_done = 1'b0;
    endfunction

    // Compare one field; print it while few mismatches have been reported.
    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want, inout logic bad);
        if (got !== want)
        begin
            bad = 1'b1;
            if (mismatch_total < 10)
                $display("verdict %0d: %s expected %0h, got %0h",
                         verdicts_seen, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t     seen;
        result_t     want;
        result_t     calc;
        logic        bad;
        logic        ok;
        logic        last_slot;
        logic [7:0]  b;
        int          q;

        if (!rst_n)
        begin
            restart_page();
            verdicts_due.delete();
            mismatch_total = 0;
            verdicts_seen  = 0;
        end
        else
        begin
            // Verdict side first: a verdict transferred now came from an earlier byte.
            if (verdict.valid && verdict.ready)
            begin
                seen = verdict.payload;
                if (verdicts_due.size() == 0)
                begin
                    if (mismatch_total < 10)
                        $display("verdict %0d: unexpected verdict for slot %0d",
                                 verdicts_seen, seen.slot_number);
                    mismatch_total++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    bad  = 1'b0;
                    compare_field("slot_number", seen.slot_number, want.slot_number, bad);
                    compare_field("slot_erased", seen.slot_erased, want.slot_erased, bad);
                    compare_field("slot_valid", seen.slot_valid, want.slot_valid, bad);
                    compare_field("slot_sequence", seen.slot_sequence, want.slot_sequence,
                                  bad);
                    compare_field("latest_found", seen.latest_found, want.latest_found, bad);
                    compare_field("latest_slot", seen.latest_slot, want.latest_slot, bad);
                    compare_field("latest_sequence", seen.latest_sequence,
                                  want.latest_sequence, bad);
                    compare_field("next_free_slot", seen.next_free_slot, want.next_free_slot,
                                  bad);
                    compare_field("scan_finished", seen.scan_finished, want.scan_finished,
                                  bad);
                    if (bad)
                        mismatch_total++;
                end
                verdicts_seen++;
            end

            // Byte side: advance the predicted scan by one transfer.
            if (page.valid && page.ready)
            begin
                if (page.page_start)
                    restart_page();
                if (!scan_done)
                begin
                    q = int'(rec_pos);
                    b = page.byte_value;
                    if (q == 0)
                        clear_record();
                    if (q < 8 && b != 8'hFF)
                        hdr_all_ones = 1'b0;

                    // Little-endian field capture by position in the slot.
                    if (q < 4)
                        rec_magic[8*q +: 8] = b;
                    else if (q < 6)
                        rec_version[8*(q-4) +: 8] = b;
                    else if (q < 8)
                        rec_size[8*(q-6) +: 8] = b;
                    else if (q < 12)
                        rec_seq[8*(q-8) +: 8] = b;
                    else if (q < PAYLOAD_START)
                        rec_crc[8*(q-12) +: 8] = b;
                    else if (q >= COMMIT_AT && q < COMMIT_AT + 4)
                        rec_commit[8*(q-COMMIT_AT) +: 8] = b;

                    // CRC covers version, size, sequence and payload.
                    if ((q >= 4 && q < 12) || (q >= PAYLOAD_START && q < COMMIT_AT))
                        crc_acc = crc_shift8(crc_acc, b);

                    calc = '0;
                    if (q == 7 && hdr_all_ones)
                    begin
                        // Erased slot: report it and end the scan.
                        scan_done            = 1'b1;
                        calc.slot_number     = slot_idx[2:0];
                        calc.slot_erased     = 1'b1;
                        calc.latest_found    = have_best;
                        calc.latest_slot     = best_idx[2:0];
                        calc.latest_sequence = best_seq;
                        calc.next_free_slot  = slot_idx[2:0];
                        calc.scan_finished   = 1'b1;
                        verdicts_due.push_back(calc);
                    end
                    else if (q + 1 >= SLOT_BYTES)
                    begin
                        // Last byte of the slot: judge the record.
                        ok = rec_magic == LOG_MAGIC && rec_version == LOG_VERSION
                             && rec_size == 16'(PAYLOAD_BYTES) && rec_commit == LOG_COMMIT
                             && rec_crc == ~crc_acc;
                        last_slot = int'(slot_idx) + 1 >= SLOT_COUNT;
                        if (ok && (!have_best || rec_seq >= best_seq))
                        begin
                            have_best = 1'b1;
                            best_idx  = slot_idx;
                            best_seq  = rec_seq;
                        end
                        calc.slot_number     = slot_idx[2:0];
                        calc.slot_valid      = ok;
                        calc.slot_sequence   = rec_seq;
                        calc.latest_found    = have_best;
                        calc.latest_slot     = best_idx[2:0];
                        calc.latest_sequence = best_seq;
                        calc.next_free_slot  = 3'(slot_idx + 1'b1);
                        calc.scan_finished   = last_slot;
                        verdicts_due.push_back(calc);
                        slot_idx = slot_t'(slot_idx + 1'b1);
                        rec_pos  = '0;
                        if (last_slot)
                            scan_done = 1'b1;
                    end
                    else
                    begin
                        rec_pos = offset_t'(q + 1);
                    end
                end
            end
        end
        verdicts_owed = verdicts_due.size();
    end

endmodule

@@ dv/tb_append_log_latest_record_scan.sv @@
// Testbench top for append_log_latest_record_scan: streams log pages built from well-formed
// and broken records, with random sender gaps and receiver stalls, and gives the verdict.
// Depends on alrs_pkg, alrs_if.sv, the block itself and alrs_scan_checker.
module tb_append_log_latest_record_scan;
    import alrs_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_VERDICTS = 60;
    localparam int RANDOM_BYTES    = 750;

    // What goes into one slot image.
    typedef enum int {
        REC_VALID,
        REC_BAD_MAGIC,
        REC_BAD_VERSION,
        REC_BAD_SIZE,
        REC_BAD_COMMIT,
        REC_BAD_CRC,
        REC_NOISE,
        REC_NEAR_ERASED,
        REC_ERASED
    } rec_kind_e;

    logic       clk = 1'b0;
    logic       rst_n;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         cycle_count = 0;
    int         bytes_sent;
    int         slots_sent;
    int         page_no;
    int         mismatch_total;
    int         verdicts_owed;
    logic [7:0] slot_img [SLOT_BYTES];

    alrs_page_if    page_ch ();
    alrs_verdict_if verdict_ch ();

    append_log_latest_record_scan DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .page    (page_ch),
        .verdict (verdict_ch)
    );

    alrs_scan_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .page           (page_ch),
        .verdict        (verdict_ch),
        .mismatch_total (mismatch_total),
        .verdicts_owed  (verdicts_owed)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** append_log_latest_record_scan: FAILED **");
            $finish;
        end
    end

    // Verdict receiver: stalls at the rate of the current phase.
    always @(posedge clk)
    begin
        verdict_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // One byte transfer, after random idle cycles.
    task automatic push_byte(input logic [7:0] b, input logic ps);
        while ($urandom_range(99) < idle_pct)
        begin
            page_ch.valid <= 1'b0;
            @(posedge clk);
        end
        page_ch.valid      <= 1'b1;
        page_ch.byte_value <= b;
        page_ch.page_start <= ps;
        @(posedge clk);
        while (!page_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic put_le(input int base, input logic [31:0] value, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            slot_img[base + i] = value[8*i +: 8];
    endtask

    // Fill slot_img with one record of the given kind and random payload.
    task automatic build_slot(input rec_kind_e kind, input logic [31:0] seq);
        logic [31:0] magic;
        logic [31:0] commit;
        logic [31:0] crc;
        logic [15:0] version;
        logic [15:0] size;
        int          flip;

        magic   = LOG_MAGIC;
        version = LOG_VERSION;
        size    = 16'(PAYLOAD_BYTES);
        commit  = LOG_COMMIT;
        for (int i = 0; i < SLOT_BYTES; i++)
            slot_img[i] = 8'($urandom_range(255));

        case (kind)
            REC_BAD_MAGIC:   magic   ^= 32'h1 << $urandom_range(31);
            REC_BAD_VERSION: version ^= 16'h1 << $urandom_range(15);
            REC_BAD_SIZE:    size    ^= 16'h1 << $urandom_range(15);
            REC_BAD_COMMIT:  commit  ^= 32'h1 << $urandom_range(31);
            default: ;
        endcase

        if (kind != REC_NOISE)
        begin
            put_le(0, magic, 4);
            put_le(4, {16'h0, version}, 2);
            put_le(6, {16'h0, size}, 2);
            put_le(8, seq, 4);
            put_le(COMMIT_AT, commit, 4);
            crc = CRC_INIT;
            for (int i = 4; i < COMMIT_AT; i++)
            begin
                if (i < 12 || i >= PAYLOAD_START)
                begin
                    crc ^= {24'h0, slot_img[i]};
                    repeat (8)
                        crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'h0);
                end
            end
            put_le(12, ~crc, 4);
        end

        // A broken CRC is either a bad stored value or a damaged payload byte.
        if (kind == REC_BAD_CRC)
        begin
            flip = $urandom_range(1) ? 12 + $urandom_range(3)
                                     : PAYLOAD_START + $urandom_range(PAYLOAD_BYTES - 1);
            slot_img[flip] ^= 8'h1 << $urandom_range(7);
        end

        // Erased header, or one that misses being erased by a single byte.
        if (kind == REC_ERASED || kind == REC_NEAR_ERASED)
        begin
            for (int i = 0; i < 8; i++)
                slot_img[i] = 8'hFF;
            if (kind == REC_NEAR_ERASED)
                slot_img[$urandom_range(7)] = 8'($urandom_range(254));
        end
    endtask

    // Send the first nbytes of a slot; page_start marks its first byte if asked.
    task automatic send_slot(input rec_kind_e kind, input logic [31:0] seq,
                             input logic ps, input int nbytes);
        build_slot(kind, seq);
        for (int i = 0; i < nbytes; i++)
            push_byte(slot_img[i], ps && i == 0);
        if (nbytes == SLOT_BYTES || (kind == REC_ERASED && nbytes == 8))
            slots_sent++;
    endtask

    // One random page: mostly good records, some broken, sometimes dropped mid-slot.
    task automatic random_page();
        int          n;
        int          cut;
        int          pick;
        rec_kind_e   kind;
        logic [31:0] seq;

        n   = ($urandom_range(3) == 0) ? SLOT_COUNT : $urandom_range(SLOT_COUNT - 1);
        cut = (n > 0 && $urandom_range(7) == 0) ? $urandom_range(n - 1) : n;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(9);
            if (pick < 6)
                kind = REC_VALID;
            else if (pick < 8)
                kind = rec_kind_e'(REC_BAD_MAGIC + $urandom_range(4));
            else if (pick == 8)
                kind = REC_NOISE;
            else
                kind = REC_NEAR_ERASED;

            // Small sequences give ties and reordering; the rest spread over all bits.
            case ($urandom_range(3))
                0:       seq = $urandom_range(5);
                1:       seq = $urandom;
                2:       seq = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
                default: seq = {$urandom_range(1) ? 16'hFFFF : 16'($urandom), 16'($urandom)};
            endcase

            if (k == cut)
            begin
                // The next page restarts the scan inside this slot.
                send_slot(kind, seq, k == 0, $urandom_range(SLOT_BYTES - 1));
                return;
            end
            send_slot(kind, seq, k == 0, SLOT_BYTES);
        end
        if (n < SLOT_COUNT)
            send_slot(REC_ERASED, 32'h0, n == 0, 8);
        // Bytes after the end of the scan are ignored.
        repeat ($urandom_range(12))
            push_byte(8'($urandom_range(255)), 1'b0);
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        page_ch.valid      <= 1'b0;
        page_ch.byte_value <= 8'h00;
        page_ch.page_start <= 1'b0;
        bytes_sent = 0;
        slots_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset arms a scan, so the first page needs no page_start.
        send_slot(REC_VALID, 32'd5, 1'b0, SLOT_BYTES);
        send_slot(REC_ERASED, 32'h0, 1'b0, 8);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);

        // Full page: sequence extremes, then each header or trailer field broken.
        send_slot(REC_VALID, 32'hFFFF_FFFF, 1'b1, SLOT_BYTES);
        send_slot(REC_VALID, 32'h0, 1'b0, SLOT_BYTES);
        for (int k = REC_BAD_MAGIC; k <= REC_BAD_CRC; k++)
            send_slot(rec_kind_e'(k), 32'h8000_0001, 1'b0, SLOT_BYTES);
        push_byte(8'hA5, 1'b0);

        // Equal sequences, noise, a near-erased header, and an erased last slot.
        send_slot(REC_VALID, 32'd7, 1'b1, SLOT_BYTES);
        send_slot(REC_VALID, 32'd7, 1'b0, SLOT_BYTES);
        send_slot(REC_NOISE, 32'h0, 1'b0, SLOT_BYTES);
        send_slot(REC_NEAR_ERASED, 32'd9, 1'b0, SLOT_BYTES);
        send_slot(REC_VALID, 32'd3, 1'b0, SLOT_BYTES);
        send_slot(REC_VALID, 32'hFFFF_FFFE, 1'b0, SLOT_BYTES);
        send_slot(REC_ERASED, 32'h0, 1'b0, 8);

        // Restart in the middle of a slot; the new page is erased at once.
        send_slot(REC_VALID, 32'd9, 1'b1, SLOT_BYTES);
        send_slot(REC_VALID, 32'd10, 1'b0, 100);
        send_slot(REC_ERASED, 32'h0, 1'b1, 8);
        push_byte(8'h5A, 1'b0);

        // A page of all-zero sequences, every one a tie.
        for (int k = 0; k < SLOT_COUNT; k++)
            send_slot(REC_VALID, 32'h0, k == 0, SLOT_BYTES);

        // Random pages, rotating through the idling phases.
        bytes_sent = 0;
        slots_sent = 0;
        page_no    = 0;
        while (slots_sent < RANDOM_VERDICTS || bytes_sent < RANDOM_BYTES)
        begin
            case (page_no % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 72; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 72; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            random_page();
            page_no++;
        end
        page_ch.valid <= 1'b0;

        // Drain the verdicts still owed, then allow a few cycles for strays.
        while (verdicts_owed != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatch_total == 0 && verdicts_owed == 0)
            $display("** append_log_latest_record_scan: PASSED **");
        else
            $display("** append_log_latest_record_scan: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
src/alrs_pkg.sv
src/alrs_if.sv
src/append_log_latest_record_scan.sv
dv/alrs_scan_checker.sv
dv/tb_append_log_latest_record_scan.sv
